// ===== rtl/core/sbpfm_pkg.sv =====
// Shared types, constants and the bar height scaler for the spectrum bar meter.
// Used by every module of the meter; depends on nothing else.
package sbpfm_pkg;

    localparam int BANDS_DEFAULT = 16;
    localparam int CFG_W         = 8;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [7:0] FRAME_PERIOD_RST   = 8'd5;
    localparam logic [7:0] HOLD_FRAMES_RST    = 8'd1;
    localparam logic [7:0] FALL_FRAMES_RST    = 8'd1;
    localparam logic [4:0] LOW_BAND_COUNT_RST = 5'd2;

    localparam int LOW_DIV   = 40;
    localparam int HIGH_DIV  = 20;
    localparam int FULL_SCALE_LEVEL = 8;

    localparam logic [5:0] SPACE_GLYPH = 6'd32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_PERIOD   = 2'd0,
        CFG_HOLD_FRAMES    = 2'd1,
        CFG_FALL_FRAMES    = 2'd2,
        CFG_LOW_BAND_COUNT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        frame_start;
        logic [3:0]  band;
        logic [15:0] magnitude;
    } sample_word_t;

    typedef struct packed {
        logic [3:0] band_out;
        logic [5:0] glyph;
        logic [3:0] level;
    } bar_word_t;

    // Per-band state kept in the band memory.
    typedef struct packed {
        logic [3:0] level;
        logic [7:0] count;
    } band_state_t;

    // Saturated quotient: counts how many multiples of the divisor, up to
    // eight, fit under the magnitude. The eight compares are independent.
    function automatic logic [3:0] bar_height(input logic [15:0] magnitude,
                                              input logic        low_band);
        logic [3:0] h;
        h = 4'd0;
        for (int k = 1; k <= FULL_SCALE_LEVEL; k++)
        begin
            if (low_band)
            begin
                if (magnitude >= 16'(k * LOW_DIV))
                    h = 4'(k);
            end
            else
            begin
                if (magnitude >= 16'(k * HIGH_DIV))
                    h = 4'(k);
            end
        end
        return h;
    endfunction

endpackage

// ===== rtl/core/sbpfm_update.sv =====
// Peak hold and fall-off update of one band's level and counter.
// Purely combinational; depends on sbpfm_pkg.
module sbpfm_update (
    input  sbpfm_pkg::band_state_t state_in,
    input  logic [3:0]             height,
    input  logic [7:0]             hold_frames,
    input  logic [7:0]             fall_frames,
    output sbpfm_pkg::band_state_t state_out
);
    import sbpfm_pkg::*;

    logic [3:0] lvl;
    logic [7:0] cnt;

    always_comb
    begin
        lvl = state_in.level;
        cnt = state_in.count;
        // A new peak raises the level and restarts the hold time.
        if (lvl < height)
        begin
            lvl = height;
            cnt = hold_frames;
        end
        if (cnt != 8'd0)
        begin
            cnt = cnt - 8'd1;
            if (cnt == 8'd0)
            begin
                if (lvl != 4'd0)
                    lvl = lvl - 4'd1;
                if (lvl != 4'd0)
                    cnt = fall_frames;
            end
        end
        state_out.level = lvl;
        state_out.count = cnt;
    end

endmodule

// ===== rtl/core/spectrum_bar_peak_fall_meter_top.sv =====
// Top level of the spectrum bar meter: frame divider, band state memory and
// the two register stages. Depends on sbpfm_pkg and sbpfm_update.
//
//   channel  direction  handshake                     word
//   sample   in         sample_valid / sample_stall   sbpfm_pkg::sample_word_t
//   bar      out        bar_valid / bar_stall         sbpfm_pkg::bar_word_t
//   cfg      in         cfg_write_en                  cfg_index, cfg_data
//
// One word is taken every cycle while sample_stall is low; a result word passes
// through the memory read stage and the output register.
// The band memory is read at acceptance and written as the word advances; the
// last write is forwarded so words for the same band may follow back to back.
// Reset clears the per-band valid bits at once, so no clearing pass is needed.
// A stalled output holds the stage behind it, which stalls the sample channel.
module spectrum_bar_peak_fall_meter_top #(
    parameter int BANDS = sbpfm_pkg::BANDS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  sbpfm_pkg::sample_word_t                sample_word,
    output logic                                   bar_valid,
    input  logic                                   bar_stall,
    output sbpfm_pkg::bar_word_t                   bar_word,
    input  logic                                   cfg_write_en,
    input  logic [sbpfm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sbpfm_pkg::CFG_W-1:0]            cfg_data
);
    import sbpfm_pkg::*;

    localparam int BAND_AW = (BANDS > 1) ? $clog2(BANDS) : 1;

    // Configuration registers.
    logic [7:0] frame_period_reg;
    logic [7:0] hold_frames_reg;
    logic [7:0] fall_frames_reg;
    logic [4:0] low_band_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_period_reg   <= FRAME_PERIOD_RST;
            hold_frames_reg    <= HOLD_FRAMES_RST;
            fall_frames_reg    <= FALL_FRAMES_RST;
            low_band_count_reg <= LOW_BAND_COUNT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_PERIOD:   frame_period_reg   <= cfg_data;
                CFG_HOLD_FRAMES:    hold_frames_reg    <= cfg_data;
                CFG_FALL_FRAMES:    fall_frames_reg    <= cfg_data;
                CFG_LOW_BAND_COUNT: low_band_count_reg <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    // Handshake control.
    logic sample_accept;
    logic stage_valid_reg, stage_valid_next;
    logic stage_adv;
    logic bar_valid_reg, bar_valid_next;

    assign stage_adv     = stage_valid_reg && (!bar_valid_reg || !bar_stall);
    assign sample_stall  = stage_valid_reg && !stage_adv;
    assign sample_accept = sample_valid && !sample_stall;

    // Frame divider, stepped on the first word of each frame.
    logic [7:0] frame_divider_reg, frame_divider_next;
    logic       frame_shown_reg, frame_shown_next;
    logic [7:0] divider_dec;

    always_comb
    begin
        divider_dec        = frame_divider_reg - 8'd1;
        frame_divider_next = frame_divider_reg;
        frame_shown_next   = frame_shown_reg;
        if (sample_accept && sample_word.frame_start)
        begin
            if (divider_dec != 8'd0)
            begin
                frame_divider_next = divider_dec;
                frame_shown_next   = 1'b0;
            end
            else
            begin
                frame_divider_next = frame_period_reg;
                frame_shown_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_divider_reg <= 8'd0;
            frame_shown_reg   <= 1'b0;
        end
        else
        begin
            frame_divider_reg <= frame_divider_next;
            frame_shown_reg   <= frame_shown_next;
        end
    end

    // Only words of shown frames on existing bands enter the stage.
    logic               band_in_range;
    logic               take_word;
    logic [BAND_AW-1:0] rd_idx;
    logic               low_band;

    assign band_in_range = 32'(sample_word.band) < 32'(BANDS);
    assign take_word     = sample_accept && frame_shown_next && band_in_range;
    assign rd_idx        = BAND_AW'(sample_word.band);
    assign low_band      = {1'b0, sample_word.band} < low_band_count_reg;

    assign stage_valid_next = take_word || (stage_valid_reg && !stage_adv);

    // Stage register: band, scaled height and the band state read.
    logic [3:0]         stage_band_reg;
    logic [3:0]         stage_height_reg;
    logic               rd_known_reg;
    band_state_t        rd_data_reg;
    band_state_t        band_mem [BANDS];
    logic [BANDS-1:0]   entry_valid_reg;

    // Last write, forwarded to a word that read the memory at that same edge.
    logic               fwd_valid_reg;
    logic [3:0]         fwd_band_reg;
    band_state_t        fwd_data_reg;

    band_state_t        cur_state;
    band_state_t        new_state;
    logic [BAND_AW-1:0] wr_idx;

    assign wr_idx = BAND_AW'(stage_band_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take_word)
        begin
            stage_band_reg   <= sample_word.band;
            stage_height_reg <= bar_height(sample_word.magnitude, low_band);
            rd_known_reg     <= entry_valid_reg[rd_idx];
            rd_data_reg      <= band_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv)
            band_mem[wr_idx] <= new_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else if (stage_adv)
        begin
            entry_valid_reg[wr_idx] <= 1'b1;
            fwd_valid_reg           <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv)
        begin
            fwd_band_reg <= stage_band_reg;
            fwd_data_reg <= new_state;
        end
    end

    always_comb
    begin
        if (fwd_valid_reg && (fwd_band_reg == stage_band_reg))
            cur_state = fwd_data_reg;
        else if (rd_known_reg)
            cur_state = rd_data_reg;
        else
            cur_state = '0;
    end

    sbpfm_update u_update (
        .state_in    (cur_state),
        .height      (stage_height_reg),
        .hold_frames (hold_frames_reg),
        .fall_frames (fall_frames_reg),
        .state_out   (new_state)
    );

    // Output register.
    bar_word_t bar_word_reg;

    assign bar_valid_next = stage_adv || (bar_valid_reg && bar_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bar_valid_reg <= 1'b0;
        else
            bar_valid_reg <= bar_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv)
        begin
            bar_word_reg.band_out <= stage_band_reg;
            bar_word_reg.level    <= new_state.level;
            bar_word_reg.glyph    <= (new_state.level != 4'd0)
                                     ? 6'(new_state.level - 4'd1) : SPACE_GLYPH;
        end
    end

    assign bar_valid = bar_valid_reg;
    assign bar_word  = bar_word_reg;

endmodule

// ===== rtl/core/sbpfm_checker.sv =====
// Port-level checks for the spectrum bar meter, bound to the top level.
// Depends on sbpfm_pkg and spectrum_bar_peak_fall_meter_top.
module sbpfm_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    sample_stall,
    input logic                    bar_valid,
    input logic                    bar_stall,
    input sbpfm_pkg::bar_word_t    bar_word
);
    import sbpfm_pkg::*;

    // A stalled result word stays put.
    a_bar_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bar_valid && bar_stall |=> bar_valid && $stable(bar_word))
        else $error("bar word changed while stalled");

    // The sample side only stalls when the result side is backed up.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> bar_valid && bar_stall)
        else $error("sample stalled without output back pressure");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        bar_valid |-> bar_word.level <= 4'(FULL_SCALE_LEVEL))
        else $error("bar level above full scale");

    // The glyph is always derived from the level it is sent with.
    a_glyph_match: assert property (@(posedge clk) disable iff (!rst_n)
        bar_valid |-> ((bar_word.level == 4'd0 && bar_word.glyph == SPACE_GLYPH) ||
                       (bar_word.level != 4'd0 &&
                        bar_word.glyph == 6'(bar_word.level - 4'd1))))
        else $error("glyph does not match level");

endmodule

bind spectrum_bar_peak_fall_meter_top sbpfm_checker u_sbpfm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .bar_valid    (bar_valid),
    .bar_stall    (bar_stall),
    .bar_word     (bar_word)
);

// ===== bench/spectrum_bar_peak_fall_meter_top_tb.sv =====
// Self-checking bench for spectrum_bar_peak_fall_meter_top: a directed table, then random frames.
// A local model of the frame divider and the per-band hold and fall predicts the bar words the table does not type.
// Depends on sbpfm_pkg for the word types and the register indexes.
module spectrum_bar_peak_fall_meter_top_tb;

    import sbpfm_pkg::*;

    localparam int          CYCLE_LIMIT     = 2000000;
    localparam int          ITEMS_TARGET    = 2000;
    localparam int          PHASE_WORDS     = 250;
    localparam int          PHASE_SENT_CAP  = 1500;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          DRAIN_LIMIT     = 5000;
    localparam int          PRINT_LIMIT     = 50;
    localparam int          BAND_COUNT      = 16;
    localparam int unsigned DIV_LOW_BANDS   = 40;
    localparam int unsigned DIV_HIGH_BANDS  = 20;
    localparam int unsigned TOP_LEVEL       = 8;
    localparam logic [5:0]  GLYPH_BLANK     = 6'd32;

    typedef enum {ROW_WORD, ROW_SETTINGS, ROW_SKIP} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        frame_start;
        logic [3:0]  band;
        logic [15:0] magnitude;
        bit          typed;
        bit          shows;
        logic [5:0]  glyph;
        logic [3:0]  level;
        logic [7:0]  period;
        logic [7:0]  hold;
        logic [7:0]  fall;
        logic [4:0]  low;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_stall;
    sample_word_t           sample_word;
    logic                   bar_valid;
    logic                   bar_stall;
    bar_word_t              bar_word;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    // Register copies and meter state as the block should hold them.
    logic [7:0] set_period = 8'd5;
    logic [7:0] set_hold   = 8'd1;
    logic [7:0] set_fall   = 8'd1;
    logic [4:0] set_low    = 5'd2;
    logic [7:0] frame_count = 8'd0;
    logic       frame_on    = 1'b0;
    logic [3:0] band_level [BAND_COUNT];
    logic [7:0] band_count [BAND_COUNT];

    bar_word_t  pending_bars [$];
    plan_row_t  plan [$];
    int         shown_words      = 0;
    int         mismatches       = 0;
    int         cycle_count      = 0;
    bit         tx_quiet         = 1'b0;
    bit         rx_quiet         = 1'b0;
    bit         hold_off_request = 1'b0;

    spectrum_bar_peak_fall_meter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .bar_valid    (bar_valid),
        .bar_stall    (bar_stall),
        .bar_word     (bar_word),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[spectrum_bar_peak_fall_meter_top] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t bar mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Advances the frame divider and the band state for one sample word.
    // Returns 1 with the bar word when the word falls in a shown frame.
    function automatic bit meter_update(input sample_word_t w, output bar_word_t bar);
        int unsigned divisor;
        int unsigned height;
        logic [3:0]  lvl;
        logic [7:0]  cnt;
        bar = '0;
        if (w.frame_start)
        begin
            frame_count = frame_count - 8'd1;
            if (frame_count != 8'd0)
                frame_on = 1'b0;
            else
            begin
                frame_count = set_period;
                frame_on = 1'b1;
            end
        end
        if (!frame_on)
            return 1'b0;
        divisor = (int'(w.band) < int'(set_low)) ? DIV_LOW_BANDS : DIV_HIGH_BANDS;
        height = int'(w.magnitude) / divisor;
        if (height > TOP_LEVEL)
            height = TOP_LEVEL;
        lvl = band_level[w.band];
        cnt = band_count[w.band];
        if (lvl < height)
        begin
            lvl = 4'(height);
            cnt = set_hold;
        end
        if (cnt != 8'd0)
        begin
            cnt = cnt - 8'd1;
            if (cnt == 8'd0)
            begin
                if (lvl != 4'd0)
                    lvl = lvl - 4'd1;
                if (lvl != 4'd0)
                    cnt = set_fall;
            end
        end
        band_level[w.band] = lvl;
        band_count[w.band] = cnt;
        bar.band_out = w.band;
        bar.glyph = (lvl != 4'd0) ? 6'(lvl - 4'd1) : GLYPH_BLANK;
        bar.level = lvl;
        return 1'b1;
    endfunction

    function automatic void plan_word(input logic fs, input logic [3:0] band,
                                      input logic [15:0] mag, input bit typed, input bit shows,
                                      input logic [5:0] glyph, input logic [3:0] level);
        plan_row_t row;
        row = '{default: '0, kind: ROW_WORD};
        row.frame_start = fs;
        row.band = band;
        row.magnitude = mag;
        row.typed = typed;
        row.shows = shows;
        row.glyph = glyph;
        row.level = level;
        plan.push_back(row);
    endfunction

    function automatic void plan_settings(input logic [7:0] period, input logic [7:0] hold,
                                          input logic [7:0] fall, input logic [4:0] low);
        plan_row_t row;
        row = '{default: '0, kind: ROW_SETTINGS};
        row.period = period;
        row.hold = hold;
        row.fall = fall;
        row.low = low;
        plan.push_back(row);
    endfunction

    function automatic void plan_skip();
        plan_row_t row;
        row = '{default: '0, kind: ROW_SKIP};
        plan.push_back(row);
    endfunction

    function automatic logic [7:0] pick_frames();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 8'($urandom_range(0, 3));
        else if (pick < 70)
            return 8'($urandom_range(4, 10));
        else if (pick < 85)
            return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one sample word and waits for it to be taken. A typed expectation
    // replaces the predicted one, but the local state still advances.
    task automatic send_word(input sample_word_t w, input bit typed, input bit typed_shows,
                             input bar_word_t typed_bar);
        bit        shows;
        bar_word_t bar;
        sample_valid <= 1'b1;
        sample_word <= w;
        do
            @(posedge clk);
        while (sample_stall);
        shows = meter_update(w, bar);
        if (typed)
        begin
            shows = typed_shows;
            bar = typed_bar;
        end
        if (shows)
        begin
            pending_bars.push_back(bar);
            shown_words++;
        end
    endtask

    task automatic sender_gap();
        int pick;
        int gap;
        if (tx_quiet)
            return;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            gap = 0;
        else if (pick < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every expected bar word is out.
    task automatic drain_bars();
        int waited;
        waited = 0;
        sample_valid <= 1'b0;
        while (pending_bars.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_bars.size() != 0)
        begin
            report_mismatch("bar words never arrived", 0, pending_bars.size());
            pending_bars.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] period, input logic [7:0] hold,
                                  input logic [7:0] fall, input logic [4:0] low);
        drain_bars();
        cfg_write_en <= 1'b1;
        cfg_index <= CFG_FRAME_PERIOD;
        cfg_data <= period;
        @(posedge clk);
        cfg_index <= CFG_HOLD_FRAMES;
        cfg_data <= hold;
        @(posedge clk);
        cfg_index <= CFG_FALL_FRAMES;
        cfg_data <= fall;
        @(posedge clk);
        cfg_index <= CFG_LOW_BAND_COUNT;
        cfg_data <= {3'b000, low};
        @(posedge clk);
        cfg_write_en <= 1'b0;
        set_period = period;
        set_hold = hold;
        set_fall = fall;
        set_low = low;
    endtask

    // Sends one-word skipped frames until the next frame start shows a frame.
    task automatic run_to_shown_frame();
        sample_word_t w;
        while (frame_count != 8'd1)
        begin
            w.frame_start = 1'b1;
            w.band = 4'($urandom_range(0, 15));
            w.magnitude = 16'($urandom_range(0, 65535));
            send_word(w, 1'b0, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin : bar_check
        bar_word_t want;
        if (rst_n && bar_valid && !bar_stall)
        begin
            if (pending_bars.size() == 0)
                report_mismatch("unexpected bar word, band", bar_word.band_out, -1);
            else
            begin
                want = pending_bars.pop_front();
                if (bar_word.band_out !== want.band_out)
                    report_mismatch("band_out", bar_word.band_out, want.band_out);
                if (bar_word.glyph !== want.glyph)
                    report_mismatch("glyph", bar_word.glyph, want.glyph);
                if (bar_word.level !== want.level)
                    report_mismatch("level", bar_word.level, want.level);
            end
        end
    end

    initial
    begin : receiver
        int pick;
        int run;
        bar_stall = 1'b0;
        forever
        begin
            if (hold_off_request)
            begin
                bar_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else if (rx_quiet)
            begin
                bar_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    bar_stall <= 1'b0;
                    run = $urandom_range(1, 4);
                end
                else if (pick < 93)
                begin
                    bar_stall <= 1'b1;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    bar_stall <= 1'b1;
                    run = $urandom_range(10, 40);
                end
                repeat (run) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        sample_word_t w;
        bar_word_t    typed_bar;
        int           phase;
        int           frames;
        int           k;
        int           len;
        int           pick;
        int           mag;
        int           goal;
        int           phase_base;
        int           phase_sent;
        bit           ordered;
        logic [3:0]   prev_band;
        logic [7:0]   period;
        logic [4:0]   low;

        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample_word = '0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_FRAME_PERIOD;
        cfg_data = '0;
        for (int b = 0; b < BAND_COUNT; b++)
        begin
            band_level[b] = 4'd0;
            band_count[b] = 8'd0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing shows before a frame start, nor in the first frame: the
        // divider wraps from zero to 255 on that start.
        plan_word(1'b0, 4'd0, 16'hFFFF, 1, 0, 6'd0, 4'd0);
        plan_word(1'b0, 4'd15, 16'h0000, 1, 0, 6'd0, 4'd0);
        plan_word(1'b1, 4'd5, 16'hFFFF, 1, 0, 6'd0, 4'd0);
        // Every frame shown, no hold and no fall: levels only rise.
        plan_settings(8'd1, 8'd0, 8'd0, 5'd2);
        plan_skip();
        plan_word(1'b1, 4'd0, 16'hFFFF, 1, 1, 6'd7, 4'd8);
        plan_word(1'b0, 4'd15, 16'hFFFF, 1, 1, 6'd7, 4'd8);
        plan_word(1'b0, 4'd1, 16'd0, 1, 1, GLYPH_BLANK, 4'd0);
        plan_word(1'b0, 4'd2, 16'd19, 1, 1, GLYPH_BLANK, 4'd0);
        plan_word(1'b0, 4'd2, 16'd20, 1, 1, 6'd0, 4'd1);
        plan_word(1'b0, 4'd1, 16'd39, 1, 1, GLYPH_BLANK, 4'd0);
        plan_word(1'b0, 4'd1, 16'd40, 1, 1, 6'd0, 4'd1);
        plan_word(1'b0, 4'd3, 16'd159, 1, 1, 6'd6, 4'd7);
        plan_word(1'b0, 4'd3, 16'd160, 1, 1, 6'd7, 4'd8);
        plan_word(1'b0, 4'd3, 16'd0, 1, 1, 6'd7, 4'd8);
        plan_word(1'b0, 4'd2, 16'd60, 1, 1, 6'd2, 4'd3);
        plan_word(1'b0, 4'd2, 16'd21, 1, 1, 6'd2, 4'd3);
        plan_word(1'b1, 4'd0, 16'd0, 1, 1, 6'd7, 4'd8);
        // Every other frame shown, with a held peak that then falls.
        plan_settings(8'd2, 8'd2, 8'd1, 5'd16);
        plan_skip();
        plan_word(1'b1, 4'd0, 16'd320, 0, 0, 6'd0, 4'd0);
        plan_word(1'b1, 4'd7, 16'd0, 0, 0, 6'd0, 4'd0);
        plan_word(1'b0, 4'd0, 16'hFFFF, 0, 0, 6'd0, 4'd0);
        plan_word(1'b1, 4'd0, 16'd0, 0, 0, 6'd0, 4'd0);
        plan_word(1'b0, 4'd15, 16'd319, 0, 0, 6'd0, 4'd0);
        // Largest register values; a low band count above 16 puts all bands low.
        plan_settings(8'd255, 8'd255, 8'd255, 5'd31);
        plan_skip();
        plan_word(1'b1, 4'd15, 16'hFFFF, 1, 1, 6'd7, 4'd8);
        plan_word(1'b0, 4'd15, 16'd100, 1, 1, 6'd7, 4'd8);
        // Zero period shows only every 256th frame; zero fall time.
        plan_settings(8'd0, 8'd1, 8'd0, 5'd0);
        plan_skip();
        plan_word(1'b1, 4'd0, 16'hFFFF, 0, 0, 6'd0, 4'd0);
        plan_word(1'b0, 4'd0, 16'd0, 0, 0, 6'd0, 4'd0);
        plan_word(1'b0, 4'd1, 16'd39, 0, 0, 6'd0, 4'd0);

        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_WORD:
                begin
                    w.frame_start = plan[i].frame_start;
                    w.band = plan[i].band;
                    w.magnitude = plan[i].magnitude;
                    typed_bar.band_out = plan[i].band;
                    typed_bar.glyph = plan[i].glyph;
                    typed_bar.level = plan[i].level;
                    send_word(w, plan[i].typed, plan[i].shows, typed_bar);
                    sender_gap();
                end
                ROW_SETTINGS:
                    apply_settings(plan[i].period, plan[i].hold, plan[i].fall, plan[i].low);
                default:
                    run_to_shown_frame();
            endcase
        end

        goal = shown_words + ITEMS_TARGET;
        phase = 0;
        prev_band = 4'd0;
        while (shown_words < goal)
        begin
            if (phase == 0)
                apply_settings(8'd1, 8'd3, 8'd2, 5'd2);
            else if (phase == 1)
                apply_settings(8'd2, 8'd255, 8'd255, 5'd16);
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    period = 8'd0;
                else if (pick < 10)
                    period = 8'd255;
                else
                    period = 8'($urandom_range(1, 4));
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    low = 5'd0;
                else if (pick < 30)
                    low = 5'd16;
                else if (pick < 50)
                    low = 5'($urandom_range(17, 31));
                else
                    low = 5'($urandom_range(0, 16));
                apply_settings(period, pick_frames(), pick_frames(), low);
            end

            // First phase: the receiver holds off while words keep coming,
            // so the pipeline fills and stalls the sample channel.
            if (phase == 0)
            begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b0;
                hold_off_request = 1'b1;
            end

            phase_base = shown_words;
            phase_sent = 0;
            frames = 0;
            while (shown_words - phase_base < PHASE_WORDS && phase_sent < PHASE_SENT_CAP)
            begin
                if (frame_count == 8'd1)
                    len = ($urandom_range(0, 9) < 6) ? BAND_COUNT : $urandom_range(1, 16);
                else
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : 1;
                ordered = ($urandom_range(0, 9) < 7);
                for (k = 0; k < len; k++)
                begin
                    // A stray frame start inside a frame breaks it up.
                    w.frame_start = (k == 0) || ($urandom_range(0, 99) < 3);
                    if (ordered)
                        w.band = 4'(k);
                    else if (k > 0 && $urandom_range(0, 3) == 0)
                        w.band = prev_band;
                    else
                        w.band = 4'($urandom_range(0, 15));
                    prev_band = w.band;
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        mag = $urandom_range(0, 400);
                    else if (pick < 65)
                        mag = int'($urandom_range(0, 9)) * (($urandom_range(0, 1) == 1) ? 40 : 20)
                              - int'($urandom_range(0, 1));
                    else if (pick < 85)
                        mag = $urandom_range(0, 65535);
                    else if (pick < 93)
                        mag = 0;
                    else
                        mag = 65535;
                    if (mag < 0)
                        mag = 0;
                    w.magnitude = 16'(mag);
                    send_word(w, 1'b0, 1'b0, '0);
                    phase_sent++;
                    sender_gap();
                end
                frames++;
                if ((phase == 0 && frames == 8) || $urandom_range(0, 49) == 0)
                    drain_bars();
            end

            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            phase++;
        end

        drain_bars();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[spectrum_bar_peak_fall_meter_top] OK");
        else
            $display("[spectrum_bar_peak_fall_meter_top] ERROR");
        $finish;
    end

endmodule
